// ===== rtl/iterated_three_tap_altitude_smoother_core_defines.svh =====
// Assertion macros for the cascaded altitude smoother.
// Used by the top level; needs clk_i and rst_ni in the enclosing scope.
`ifndef ITERATED_THREE_TAP_ALTITUDE_SMOOTHER_CORE_DEFINES_SVH
`define ITERATED_THREE_TAP_ALTITUDE_SMOOTHER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define ITAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the following cycle.
`define ITAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ITAS_ASSERT(lbl, prop, msg)
`define ITAS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/itas_pkg.sv =====
// Shared types and constants of the cascaded altitude smoother.
// No dependencies.
package itas_pkg;

  // Number of smoothing passes (cells in the chain).
  localparam int PASSES      = 20;
  // Sample width, signed, 8 fraction bits.
  localparam int SAMPLE_BITS = 24;
  // Coefficient fraction bits and accumulator width.
  localparam int FRAC_SHIFT  = 16;
  localparam int ACC_W       = SAMPLE_BITS + 18;

  // Q0.16 weights: 0.3 on each side, 0.4 in the middle (sum is exactly one).
  localparam logic signed [ACC_W-1:0] COEF_SIDE = ACC_W'(19661);
  localparam logic signed [ACC_W-1:0] COEF_MID  = ACC_W'(26214);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Cell occupancy.
  typedef enum logic [1:0] {
    FILL_EMPTY = 2'd0,
    FILL_FIRST = 2'd1,
    FILL_INNER = 2'd2
  } fill_e;

  // One beat travelling along the chain.
  typedef struct packed {
    sample_t value;
    logic    last;
  } beat_t;

  // Status a cell reports to the top level.
  typedef struct packed {
    fill_e fill;
    logic  pend;
  } cell_stat_t;

endpackage

// ===== rtl/itas_stream_if.sv =====
// Valid/ready stream interfaces for the altitude smoother's input and output.
// Depends on itas_pkg.
interface itas_in_if;
  import itas_pkg::*;

  logic    valid;
  logic    ready;
  sample_t altitude;
  logic    final_point;

  modport source (output valid, altitude, final_point, input ready);
  modport sink   (input valid, altitude, final_point, output ready);
endinterface

interface itas_out_if;
  import itas_pkg::*;

  logic    valid;
  logic    ready;
  sample_t smoothed_altitude;
  logic    final_result;

  modport source (output valid, smoothed_altitude, final_result, input ready);
  modport sink   (input valid, smoothed_altitude, final_result, output ready);
endinterface

// ===== rtl/itas_cell.sv =====
// One smoothing pass: holds two samples and emits 0.3/0.4/0.3 results, passing the end samples through unchanged.
// Depends on itas_pkg.
module itas_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  itas_pkg::beat_t       in_beat_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output itas_pkg::beat_t       out_beat_o,
  input  logic                  out_ready_i,
  output itas_pkg::cell_stat_t  stat_o
);
  import itas_pkg::*;

  sample_t          older_q, older_d;
  sample_t          newer_q, newer_d;
  fill_e            fill_q, fill_d;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  beat_t            out_q, out_d;

  logic             out_free;
  logic             take;
  logic signed [SAMPLE_BITS:0] side_sum;
  logic signed [ACC_W-1:0]     acc;
  sample_t          smooth;

  // Accept a beat when no flush beat waits and the output register frees up.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !pend_q && out_free;
  assign take       = in_valid_i && in_ready_o;

  // Weighted sum with half-up rounding, then floor shift.
  assign side_sum = {older_q[SAMPLE_BITS-1], older_q}
                  + {in_beat_i.value[SAMPLE_BITS-1], in_beat_i.value};
  assign acc      = ACC_W'(side_sum) * COEF_SIDE
                  + ACC_W'(newer_q) * COEF_MID + ROUND_HALF;
  assign smooth   = acc[FRAC_SHIFT +: SAMPLE_BITS];

  // Next state of the cell.
  always_comb begin
    older_d     = older_q;
    newer_d     = newer_q;
    fill_d      = fill_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (pend_q && out_ready_i) begin
      // Emit the held final sample after the last interior result.
      out_valid_d = 1'b1;
      out_d.value = newer_q;
      out_d.last  = 1'b1;
      pend_d      = 1'b0;
    end else if (take) begin
      unique case (fill_q)
        FILL_FIRST, FILL_INNER: begin
          out_valid_d = 1'b1;
          out_d.value = (fill_q == FILL_FIRST) ? newer_q : smooth;
          out_d.last  = 1'b0;
          older_d     = newer_q;
          newer_d     = in_beat_i.value;
          if (in_beat_i.last) begin
            pend_d = 1'b1;
            fill_d = FILL_EMPTY;
          end else begin
            fill_d = FILL_INNER;
          end
        end
        default: begin
          if (in_beat_i.last) begin
            // Single-point track: pass straight through.
            out_valid_d = 1'b1;
            out_d.value = in_beat_i.value;
            out_d.last  = 1'b1;
          end else begin
            newer_d = in_beat_i.value;
            fill_d  = FILL_FIRST;
          end
        end
      endcase
    end
  end

  // Hold control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= FILL_EMPTY;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold samples and the output beat.
  always_ff @(posedge clk_i) begin
    older_q <= older_d;
    newer_q <= newer_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;
  assign stat_o.fill = fill_q;
  assign stat_o.pend = pend_q;

endmodule

// ===== rtl/iterated_three_tap_altitude_smoother_core.sv =====
// Cascaded three-tap altitude smoother: a chain of PASSES smoothing cells.
// Depends on itas_pkg, itas_stream_if, itas_cell and the defines header.
//
// Usage:
//  - in_i carries altitude samples of one track (signed, 8 fraction bits);
//    final_point marks the last sample. out_o delivers the smoothed samples
//    in input order; final_result marks the last one of the track.
//  - Each of the PASSES cells holds two samples and an output register, so
//    a cell registers its result for a sample when the next sample enters, and the first result
//    of a track appears once PASSES+1 samples have entered.
//  - Throughput is one beat per cycle while the track streams and the receiver keeps ready high. A final
//    sample makes each cell emit two beats; a cell holding its extra beat
//    drops its input ready until that beat leaves, so the flush delivers PASSES+1
//    results, one per cycle when the receiver keeps ready high.
//  - A receiver stall holds the last cell's output; the stall propagates
//    back cell by cell and finally lowers in_i.ready. No beat is lost.
//  - Reset empties every cell and clears all output valids; the next sample
//    starts a new track. After a final sample the cells are empty again.
`include "iterated_three_tap_altitude_smoother_core_defines.svh"

module iterated_three_tap_altitude_smoother_core (
  input logic  clk_i,
  input logic  rst_ni,
  itas_in_if.sink    in_i,
  itas_out_if.source out_o
);
  import itas_pkg::*;

  beat_t      link  [PASSES+1];
  logic       vld   [PASSES+1];
  logic       rdy   [PASSES+1];
  cell_stat_t stat  [PASSES];
  logic [PASSES-1:0] pend_vec;
  logic [PASSES-1:0] busy_vec;
  logic [PASSES-1:0] open_vec;
  logic              final_take;

  // Feed the chain from the input channel.
  assign vld[0]        = in_i.valid;
  assign link[0].value = in_i.altitude;
  assign link[0].last  = in_i.final_point;
  assign in_i.ready    = rdy[0];

  // Build the chain of smoothing cells.
  for (genvar k = 0; k < PASSES; k++) begin : g_cell
    itas_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[k]),
      .in_beat_i   (link[k]),
      .in_ready_o  (rdy[k]),
      .out_valid_o (vld[k+1]),
      .out_beat_o  (link[k+1]),
      .out_ready_i (rdy[k+1]),
      .stat_o      (stat[k])
    );
    assign pend_vec[k] = stat[k].pend;
    assign busy_vec[k] = vld[k+1];
    assign open_vec[k] = rdy[k];
  end

  // Drive the output channel from the last cell.
  assign out_o.valid             = vld[PASSES];
  assign out_o.smoothed_altitude = link[PASSES].value;
  assign out_o.final_result      = link[PASSES].last;
  assign rdy[PASSES]             = out_o.ready;

  // Flag an accepted final sample.
  assign final_take = in_i.valid && in_i.ready && in_i.final_point;

  // A waiting flush beat always sits behind a valid output beat.
  `ITAS_ASSERT(a_pend_has_out, (pend_vec & ~busy_vec) == '0, "flush beat without output")
  // A cell with a waiting flush beat takes no input.
  `ITAS_ASSERT(a_pend_blocks_in, (pend_vec & open_vec) == '0, "cell open while flushing")
  // A final sample leaves the first cell empty.
  `ITAS_ASSERT_NEXT(a_final_empties, final_take, stat[0].fill == FILL_EMPTY, "first cell not empty")

endmodule

// ===== test/tb_iterated_three_tap_altitude_smoother_core.sv =====
`timescale 1ns / 100ps
// Testbench for the cascaded three-tap altitude smoother: directed and random bursty tracks in,
// stalled receiver out, every result beat checked against an in-bench cascade model.
// Depends on itas_pkg, the itas stream interfaces and the smoother core.

import itas_pkg::*;

// Cascade model and store of smoothed beats still owed by the block.
class smoothed_track_checker;
  localparam longint SIDE_WEIGHT = 19661;
  localparam longint MID_WEIGHT  = 26214;
  localparam longint HALF_LSB    = 32768;

  sample_t     older_alt[PASSES];
  sample_t     newer_alt[PASSES];
  fill_e       occupancy[PASSES];
  beat_t       smoothed_due_q[$];
  int unsigned errors;

  function new();
    foreach (occupancy[p]) begin
      older_alt[p] = '0;
      newer_alt[p] = '0;
      occupancy[p] = FILL_EMPTY;
    end
    errors = 0;
  endfunction

  // 0.3/0.4/0.3 weighting, rounded half up by a floor shift.
  function sample_t blend_three(sample_t a, sample_t b, sample_t c);
    longint acc;
    acc = SIDE_WEIGHT * (longint'(a) + longint'(c)) + MID_WEIGHT * longint'(b) + HALF_LSB;
    return sample_t'(acc >>> 16);
  endfunction

  // One smoothing pass: take a beat, emit whatever the cell releases.
  function void pass_through_cell(int p, beat_t x, ref beat_t released[$]);
    beat_t o;
    if (occupancy[p] == FILL_EMPTY) begin
      if (x.last) begin
        released.push_back(x);
      end else begin
        newer_alt[p] = x.value;
        occupancy[p] = FILL_FIRST;
      end
    end else begin
      o.value = (occupancy[p] == FILL_FIRST) ? newer_alt[p] :
                blend_three(older_alt[p], newer_alt[p], x.value);
      o.last  = 1'b0;
      released.push_back(o);
      older_alt[p] = newer_alt[p];
      newer_alt[p] = x.value;
      occupancy[p] = FILL_INNER;
      // flush the cell on the track's last point
      if (x.last) begin
        released.push_back(x);
        occupancy[p] = FILL_EMPTY;
      end
    end
  endfunction

  function void record_point(sample_t alt, logic fin);
    beat_t stage[$];
    beat_t released[$];
    beat_t b;
    b.value = alt;
    b.last  = fin;
    stage.push_back(b);
    for (int p = 0; p < PASSES; p++) begin
      released = {};
      foreach (stage[i]) pass_through_cell(p, stage[i], released);
      stage = released;
    end
    foreach (stage[i]) smoothed_due_q.push_back(stage[i]);
  endfunction

  function void check_smoothed(sample_t alt, logic fin);
    beat_t due;
    if (smoothed_due_q.size() == 0) begin
      $error("unexpected result beat: smoothed_altitude %0d, final_result %0b", alt, fin);
      errors++;
    end else begin
      due = smoothed_due_q.pop_front();
      if (alt !== due.value) begin
        $error("smoothed_altitude: expected %0d, actual %0d", due.value, alt);
        errors++;
      end
      if (fin !== due.last) begin
        $error("final_result: expected %0b, actual %0b", due.last, fin);
        errors++;
      end
    end
  endfunction

  function int pending();
    return smoothed_due_q.size();
  endfunction
endclass

module tb_iterated_three_tap_altitude_smoother_core;

  localparam sample_t MAX_ALT = sample_t'(24'h7FFFFF);
  localparam sample_t MIN_ALT = sample_t'(24'h800000);
  localparam int      TARGET_POINTS = 230;

  typedef enum int {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_RARELY,
    RX_PERIODIC,
    RX_HOLD
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  itas_in_if  in_bus ();
  itas_out_if out_bus ();

  smoothed_track_checker board = new();

  int          burst_left;
  int unsigned points_sent;

  iterated_three_tap_altitude_smoother_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Check every result beat the receiver accepts
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      board.check_smoothed(out_bus.smoothed_altitude, out_bus.final_result);
    end
  end

  // Receiver: stall in stretches of changing character
  initial begin
    rx_mode_e    mode;
    int unsigned stretch;
    int unsigned tick;
    out_bus.ready = 1'b0;
    tick = 0;
    forever begin
      mode    = rx_mode_e'($urandom_range(0, 4));
      stretch = (mode == RX_HOLD) ? $urandom_range(5, 40) : $urandom_range(10, 60);
      repeat (stretch) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          RX_ALWAYS:   out_bus.ready <= 1'b1;
          RX_MOSTLY:   out_bus.ready <= ($urandom_range(0, 3) != 0);
          RX_RARELY:   out_bus.ready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_bus.ready <= (tick % 3 != 0);
          default:     out_bus.ready <= 1'b0;
        endcase
      end
    end
  end

  // Present one point, wait for the handshake; gaps fall between bursts
  task automatic send_point(input sample_t alt, input logic fin);
    if (burst_left <= 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 24);
    end
    in_bus.valid       <= 1'b1;
    in_bus.altitude    <= alt;
    in_bus.final_point <= fin;
    do @(posedge clk_i); while (!in_bus.ready);
    board.record_point(alt, fin);
    burst_left--;
    points_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_track(input sample_t pts[$]);
    foreach (pts[i]) send_point(pts[i], i == pts.size() - 1);
  endtask

  // Random track: mostly a smooth walk, sometimes raw noise or rail-to-rail jumps
  task automatic send_random_track();
    sample_t     pts[$];
    int unsigned len;
    int unsigned flavour;
    int          span;
    longint      walk;
    case ($urandom_range(0, 9))
      0:       len = 1;
      1:       len = 2;
      8, 9:    len = $urandom_range(31, 60);
      default: len = $urandom_range(3, 30);
    endcase
    flavour = $urandom_range(0, 7);
    span    = 1 << $urandom_range(0, 14);
    walk    = longint'(sample_t'($urandom));
    for (int i = 0; i < len; i++) begin
      if (flavour == 0) begin
        pts.push_back(sample_t'($urandom));
      end else if (flavour == 1) begin
        pts.push_back($urandom_range(0, 1) ? MAX_ALT : MIN_ALT);
      end else begin
        walk = walk + longint'($urandom_range(0, 2 * span)) - span;
        if (walk > longint'(MAX_ALT)) walk = longint'(MAX_ALT);
        if (walk < longint'(MIN_ALT)) walk = longint'(MIN_ALT);
        pts.push_back(sample_t'(walk));
      end
    end
    run_track(pts);
  endtask

  // Stimulus and end of run
  initial begin
    sample_t pts[$];
    in_bus.valid       = 1'b0;
    in_bus.altitude    = '0;
    in_bus.final_point = 1'b0;
    burst_left         = 0;
    points_sent        = 0;
    rst_ni             = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-point tracks pass straight through with the final mark
    pts = {MAX_ALT};
    run_track(pts);
    pts = {MIN_ALT};
    run_track(pts);
    pts = {sample_t'(0)};
    run_track(pts);
    // two-point track: both ends unchanged
    pts = {MAX_ALT, MIN_ALT};
    run_track(pts);
    // three points, interior swings between the rails
    pts = {MIN_ALT, MAX_ALT, MIN_ALT};
    run_track(pts);
    // small values around zero exercise rounding of negatives
    pts = {sample_t'(-1), sample_t'(0), sample_t'(1), sample_t'(-2)};
    run_track(pts);
    // alternating rails through every cell
    pts = {};
    for (int i = 0; i < 10; i++) pts.push_back(i[0] ? MIN_ALT : MAX_ALT);
    run_track(pts);

    while (points_sent < TARGET_POINTS) send_random_track();
    in_bus.valid <= 1'b0;

    // drain, then allow stray beats to show up
    while (board.pending() != 0) @(posedge clk_i);
    repeat (2 * PASSES + 8) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("tb_iterated_three_tap_altitude_smoother_core: PASS");
    end else begin
      $display("tb_iterated_three_tap_altitude_smoother_core: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_400_000;
    $display("tb_iterated_three_tap_altitude_smoother_core: FAIL");
    $finish;
  end

endmodule
